// ===== src/sorted_symbol_set_union_index_assert.svh =====
// Assertion macros used by the checker of the symbol set union block.
`ifndef SORTED_SYMBOL_SET_UNION_INDEX_ASSERT_SVH
`define SORTED_SYMBOL_SET_UNION_INDEX_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SSUI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssui checker: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define SSUI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssui checker: same-cycle property failed");

`endif

// ===== src/ssui_pkg.sv =====
// Package of the symbol set union block: sizes, codes and item types.
package ssui_pkg;

  // Storage sizes.
  localparam int LIST_DEPTH   = 256;
  localparam int SYMBOL_COUNT = 256;
  localparam int UNION_DEPTH  = 2 * LIST_DEPTH;

  // Widths derived from the storage sizes.
  localparam int LA_W = $clog2(LIST_DEPTH);
  localparam int LC_W = $clog2(LIST_DEPTH + 1);
  localparam int UA_W = $clog2(UNION_DEPTH);
  localparam int UC_W = $clog2(UNION_DEPTH + 1);
  localparam int TA_W = $clog2(SYMBOL_COUNT);

  // Fixed field widths of the items.
  localparam int MODE_W     = 3;
  localparam int SYMBOL_W   = 8;
  localparam int POSITION_W = 9;
  localparam int INDEX_W    = 9;
  localparam int SIZE_W     = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND_A = 3'd0,
    MODE_APPEND_B = 3'd1,
    MODE_BUILD    = 3'd2,
    MODE_LOOKUP   = 3'd3,
    MODE_READ     = 3'd4,
    MODE_CLEAR    = 3'd5
  } ssui_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NOT_FOUND    = 2'd1,
    STATUS_LIST_FULL    = 2'd2,
    STATUS_OUT_OF_RANGE = 2'd3
  } ssui_status_e;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [SYMBOL_W-1:0]   symbol;
    logic [POSITION_W-1:0] position;
  } ssui_in_t;

  typedef struct packed {
    ssui_status_e        status;
    logic [INDEX_W-1:0]  index;
    logic                found;
    logic [SYMBOL_W-1:0] symbol_out;
    logic [SIZE_W-1:0]   union_size;
  } ssui_out_t;

  // Signals from the merge engine to the controller and memories.
  typedef struct packed {
    logic                rd_en;
    logic [LA_W-1:0]     a_addr;
    logic [LA_W-1:0]     b_addr;
    logic                wr_en;
    logic [UA_W-1:0]     wr_pos;
    logic [SYMBOL_W-1:0] wr_sym;
    logic                done;
    logic [UC_W-1:0]     count;
  } ssui_merge_t;

  // True when a symbol has an entry in the reverse index table.
  function automatic logic sym_in_table(logic [SYMBOL_W-1:0] sym);
    return int'(sym) < SYMBOL_COUNT;
  endfunction

endpackage

// ===== src/ssui_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module ssui_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, and a read port whose data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ssui_merge.sv =====
// Two-pointer merge engine that walks both list memories during a build.
module ssui_merge import ssui_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [LC_W-1:0]     count_a_i,
  input  logic [LC_W-1:0]     count_b_i,
  input  logic [SYMBOL_W-1:0] a_data_i,
  input  logic [SYMBOL_W-1:0] b_data_i,
  output ssui_merge_t         merge_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_READ = 2'd1;
  localparam logic [1:0] M_STEP = 2'd2;

  logic [1:0]      mstate_q, mstate_d;
  logic [LC_W-1:0] i_q, i_d, j_q, j_d;
  logic [UC_W-1:0] k_q, k_d;
  logic            a_left, b_left, room;

  assign a_left = i_q < count_a_i;
  assign b_left = j_q < count_b_i;
  assign room   = k_q < UC_W'(UNION_DEPTH);

  // One merged entry per pass: read both heads in M_READ, then pick and write in M_STEP.
  always_comb begin
    mstate_d       = mstate_q;
    i_d            = i_q;
    j_d            = j_q;
    k_d            = k_q;
    merge_o        = '0;
    merge_o.a_addr = i_q[LA_W-1:0];
    merge_o.b_addr = j_q[LA_W-1:0];
    merge_o.wr_pos = k_q[UA_W-1:0];
    merge_o.count  = k_q;
    case (mstate_q)
      M_IDLE: begin
        if (start_i) begin
          i_d      = '0;
          j_d      = '0;
          k_d      = '0;
          mstate_d = M_READ;
        end
      end
      M_READ: begin
        if ((a_left || b_left) && room) begin
          merge_o.rd_en = 1'b1;
          mstate_d      = M_STEP;
        end else begin
          merge_o.done = 1'b1;
          mstate_d     = M_IDLE;
        end
      end
      M_STEP: begin
        merge_o.wr_en = 1'b1;
        if (a_left && b_left) begin
          if (a_data_i < b_data_i) begin
            merge_o.wr_sym = a_data_i;
            i_d            = i_q + 1'b1;
          end else if (a_data_i == b_data_i) begin
            // Equal heads go out once and both lists advance.
            merge_o.wr_sym = a_data_i;
            i_d            = i_q + 1'b1;
            j_d            = j_q + 1'b1;
          end else begin
            merge_o.wr_sym = b_data_i;
            j_d            = j_q + 1'b1;
          end
        end else if (a_left) begin
          merge_o.wr_sym = a_data_i;
          i_d            = i_q + 1'b1;
        end else begin
          merge_o.wr_sym = b_data_i;
          j_d            = j_q + 1'b1;
        end
        k_d      = k_q + 1'b1;
        mstate_d = M_READ;
      end
      default: begin
        mstate_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstate_q <= M_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else begin
      mstate_q <= mstate_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
    end
  end

endmodule

// ===== src/sorted_symbol_set_union_index.sv =====
// Channel  | Handshake               | Item
// ---------+-------------------------+------------------------------------------
// input    | in_valid_i / in_stall_o | in_item_i: mode, symbol, position
// output   | out_valid_o/out_stall_i | out_item_o: status, index, found,
//          |                         |   symbol_out, union_size
//
// Appends, clears and unused modes give their result in the cycle after acceptance.
// Lookups and reads pass through S_RESP, where the registered table or union memory read is put in the output.
// During a build each merged entry needs a read of both list memories and then a compare
// and write, and the index table is written alongside.
// Reset empties both lists and the union and clears the table's presence flags at once.
// One item is worked at a time; a new item is taken once the previous result has gone or is
// being taken, and results wait in the output register while out_stall_i is high.
module sorted_symbol_set_union_index import ssui_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ssui_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ssui_out_t out_item_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RESP  = 2'd1;
  localparam logic [1:0] S_BUILD = 2'd2;
  localparam logic [1:0] S_BDONE = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [MODE_W-1:0]       mode_q, mode_d;
  logic                    found_q, found_d;
  logic                    oor_q, oor_d;
  logic [LC_W-1:0]         count_a_q, count_a_d, count_b_q, count_b_d;
  logic [UC_W-1:0]         union_count_q, union_count_d;
  logic [SYMBOL_COUNT-1:0] valid_q, valid_d;
  logic                    out_valid_q, out_valid_d;
  ssui_out_t               out_q, out_d;

  logic                accept, out_free, out_load;
  logic                a_full, b_full;
  logic                build_start;
  ssui_merge_t         merge;
  logic [SYMBOL_W-1:0] a_rdata, b_rdata, union_rdata;
  logic [UA_W-1:0]     table_rdata;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign a_full      = count_a_q >= LC_W'(LIST_DEPTH);
  assign b_full      = count_b_q >= LC_W'(LIST_DEPTH);
  assign build_start = accept && (in_item_i.mode == MODE_BUILD);

  // List memories: appends write, the merge engine reads.
  ssui_ram #(.WIDTH(SYMBOL_W), .DEPTH(LIST_DEPTH)) u_list_a (
    .clk_i   (clk_i),
    .we_i    (accept && (in_item_i.mode == MODE_APPEND_A) && !a_full),
    .waddr_i (count_a_q[LA_W-1:0]),
    .wdata_i (in_item_i.symbol),
    .re_i    (merge.rd_en),
    .raddr_i (merge.a_addr),
    .rdata_o (a_rdata)
  );

  ssui_ram #(.WIDTH(SYMBOL_W), .DEPTH(LIST_DEPTH)) u_list_b (
    .clk_i   (clk_i),
    .we_i    (accept && (in_item_i.mode == MODE_APPEND_B) && !b_full),
    .waddr_i (count_b_q[LA_W-1:0]),
    .wdata_i (in_item_i.symbol),
    .re_i    (merge.rd_en),
    .raddr_i (merge.b_addr),
    .rdata_o (b_rdata)
  );

  // Union store: written by the merge, read by read items.
  ssui_ram #(.WIDTH(SYMBOL_W), .DEPTH(UNION_DEPTH)) u_union (
    .clk_i   (clk_i),
    .we_i    (merge.wr_en),
    .waddr_i (merge.wr_pos),
    .wdata_i (merge.wr_sym),
    .re_i    (accept && (in_item_i.mode == MODE_READ)),
    .raddr_i (UA_W'(in_item_i.position)),
    .rdata_o (union_rdata)
  );

  // Reverse index: ascending writes during the merge leave the latest position.
  ssui_ram #(.WIDTH(UA_W), .DEPTH(SYMBOL_COUNT)) u_index (
    .clk_i   (clk_i),
    .we_i    (merge.wr_en && sym_in_table(merge.wr_sym)),
    .waddr_i (TA_W'(merge.wr_sym)),
    .wdata_i (merge.wr_pos),
    .re_i    (accept && (in_item_i.mode == MODE_LOOKUP)),
    .raddr_i (TA_W'(in_item_i.symbol)),
    .rdata_o (table_rdata)
  );

  ssui_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (build_start),
    .count_a_i (count_a_q),
    .count_b_i (count_b_q),
    .a_data_i  (a_rdata),
    .b_data_i  (b_rdata),
    .merge_o   (merge)
  );

  // Presence flags: cleared when a build starts, set as the merge writes the table.
  always_comb begin
    valid_d = valid_q;
    if (build_start) begin
      valid_d = '0;
    end
    if (merge.wr_en && sym_in_table(merge.wr_sym)) begin
      valid_d[TA_W'(merge.wr_sym)] = 1'b1;
    end
  end

  // Item controller and result formation.
  always_comb begin
    state_d          = state_q;
    mode_d           = mode_q;
    found_d          = found_q;
    oor_d            = oor_q;
    count_a_d        = count_a_q;
    count_b_d        = count_b_q;
    union_count_d    = union_count_q;
    out_load         = 1'b0;
    out_d            = '0;
    out_d.status     = STATUS_OK;
    out_d.union_size = SIZE_W'(union_count_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.mode)
            MODE_APPEND_A: begin
              out_load = 1'b1;
              if (a_full) begin
                out_d.status = STATUS_LIST_FULL;
              end else begin
                count_a_d = count_a_q + 1'b1;
              end
            end
            MODE_APPEND_B: begin
              out_load = 1'b1;
              if (b_full) begin
                out_d.status = STATUS_LIST_FULL;
              end else begin
                count_b_d = count_b_q + 1'b1;
              end
            end
            MODE_BUILD: begin
              state_d = S_BUILD;
            end
            MODE_LOOKUP, MODE_READ: begin
              mode_d  = in_item_i.mode;
              found_d = valid_q[TA_W'(in_item_i.symbol)] && sym_in_table(in_item_i.symbol);
              oor_d   = int'(in_item_i.position) >= int'(union_count_q);
              state_d = S_RESP;
            end
            MODE_CLEAR: begin
              out_load  = 1'b1;
              count_a_d = '0;
              count_b_d = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RESP: begin
        // Memory data holds until the result can be registered.
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (mode_q == MODE_LOOKUP) begin
            if (found_q) begin
              out_d.index = INDEX_W'(table_rdata);
              out_d.found = 1'b1;
            end else begin
              out_d.status = STATUS_NOT_FOUND;
            end
          end else begin
            if (oor_q) begin
              out_d.status = STATUS_OUT_OF_RANGE;
            end else begin
              out_d.symbol_out = union_rdata;
            end
          end
        end
      end
      S_BUILD: begin
        if (merge.done) begin
          union_count_d = merge.count;
          state_d       = S_BDONE;
        end
      end
      S_BDONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register.
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_a_q     <= '0;
      count_b_q     <= '0;
      union_count_q <= '0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_a_q     <= count_a_d;
      count_b_q     <= count_b_d;
      union_count_q <= union_count_d;
      valid_q       <= valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    found_q <= found_d;
    oor_q   <= oor_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/ssui_checker.sv =====
// Port checker for the symbol set union block, bound to its top level.
`include "sorted_symbol_set_union_index_assert.svh"

module ssui_checker import ssui_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ssui_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ssui_out_t out_item_o
);

  logic in_take;
  logic long_take;

  assign in_take   = in_valid_i && !in_stall_o;
  assign long_take = in_take && ((in_item_i.mode == MODE_BUILD) ||
                                 (in_item_i.mode == MODE_LOOKUP));

  // A stalled result item stays and does not change.
  `SSUI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // An append to list A gives its result in the next cycle.
  `SSUI_ASSERT_NEXT(a_append_latency, in_take && (in_item_i.mode == MODE_APPEND_A), out_valid_o)

  // A build or a lookup keeps the input stalled in the following cycle.
  `SSUI_ASSERT_NEXT(a_busy_after_long, long_take, in_stall_o)

  // A found symbol always comes with an ok status.
  `SSUI_ASSERT_NOW(a_found_ok, out_valid_o && out_item_o.found, out_item_o.status == STATUS_OK)

endmodule

bind sorted_symbol_set_union_index ssui_checker u_ssui_checker (.*);
